FILE: sv/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge, off while reset is high
`define KTS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("kts assertion failed");

// property checked at every rising clock edge, reset included
`define KTS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("kts assertion failed");

`endif

FILE: sv/kts_pkg.sv
// constants and controller/datapath interface types of the topological sorter
// no dependencies
package kts_pkg;

   localparam int MAX_NODES = 16;
   localparam int NODE_W    = 4;
   localparam int CNT_W     = 5;
   localparam int DEG_W     = 5;
   localparam int NODE_COUNT_RESET = 16;

   typedef struct packed {
      logic load;
      logic pick;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic run_start;
      logic run_end;
      logic out_free;
   } status_type;

endpackage

FILE: sv/kahn_topological_sort.sv
// Kahn topological sorter of a directed graph of up to 16 nodes. Adjacency rows
// stream in one transaction per cycle; rows whose index is not below the node count
// are dropped. The row that completes the graph starts the sort, and req_tready stays
// low until the run ends. Each result passes two steps (a priority pick over the ready
// nodes, then the in-degree update of the picked node's successors with the result
// register load, which waits while the result side stalls). A graph with a cycle ends
// in one result flagged in tuser. The last result may still wait on the result side
// while the next graph loads.
// depends on kts_pkg, kts_ctrl, kts_datapath
module kahn_topological_sort
   import kts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata,   // node_count
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // row_index[3:0], row_bits[19:4], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // node[3:0], zero pad
   output logic        rsp_tlast,
   output logic        rsp_tuser    // cycle_found
);

   cmd_type    cmd;
   status_type status;

   kts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kts_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: sv/kts_ctrl.sv
// controller state machine of the topological sorter: load, pick, emit
// depends on kts_pkg
module kts_ctrl
   import kts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_PICK = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            if (req_tvalid && status.run_start) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.run_end ? ST_LOAD : ST_PICK;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/kts_datapath.sv
// datapath of the topological sorter: rows, in-degrees, removed mask, pick, result register
// depends on kts_pkg
module kts_datapath
   import kts_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata,
   input  logic [23:0]      req_tdata,
   input  cmd_type          cmd,
   output status_type       status,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tuser
);

   logic [CNT_W-1:0]     node_count_ff;
   logic [MAX_NODES-1:0] adj_ff [MAX_NODES];
   logic [DEG_W-1:0]     deg_ff [MAX_NODES];
   logic [DEG_W-1:0]     deg_in [MAX_NODES];
   logic [MAX_NODES-1:0] removed_ff, removed_in;
   logic [CNT_W-1:0]     rows_ff, rows_in;
   logic [CNT_W-1:0]     step_ff, step_in;
   logic [NODE_W-1:0]    pick_ff;
   logic                 found_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]    rsp_node_ff;
   logic                 rsp_last_ff;
   logic                 rsp_cyc_ff;

   logic [CNT_W-1:0]     n_eff;
   logic [MAX_NODES-1:0] active_mask;
   logic [NODE_W-1:0]    row_idx;
   logic [MAX_NODES-1:0] row_bits;
   logic                 row_ok;
   logic [CNT_W-1:0]     rows_next;
   logic [MAX_NODES-1:0] cand;
   logic [NODE_W-1:0]    pick_sel;
   logic [MAX_NODES-1:0] pick_row;
   logic                 run_end;

   always_comb begin
      if (node_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (node_count_ff > CNT_W'(MAX_NODES)) begin
         n_eff = CNT_W'(MAX_NODES);
      end else begin
         n_eff = node_count_ff;
      end
      for (int j = 0; j < MAX_NODES; j++) begin
         active_mask[j] = (CNT_W'(j) < n_eff);
      end
   end

   assign row_idx   = req_tdata[NODE_W-1:0];
   assign row_bits  = req_tdata[NODE_W +: MAX_NODES] & active_mask;
   assign row_ok    = {1'b0, row_idx} < n_eff;
   assign rows_next = rows_ff + CNT_W'(1);

   // ready nodes and lowest-index pick
   always_comb begin
      pick_sel = '0;
      for (int j = 0; j < MAX_NODES; j++) begin
         cand[j] = (deg_ff[j] == '0) && !removed_ff[j] && active_mask[j];
      end
      for (int j = MAX_NODES - 1; j >= 0; j--) begin
         if (cand[j]) begin
            pick_sel = NODE_W'(j);
         end
      end
   end

   assign pick_row = adj_ff[pick_ff];
   assign run_end  = !found_ff || (step_ff + CNT_W'(1) == n_eff);

   assign status.run_start = row_ok && (rows_next >= n_eff);
   assign status.run_end   = run_end;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      deg_in       = deg_ff;
      removed_in   = removed_ff;
      rows_in      = rows_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.load && row_ok) begin
         rows_in = rows_next;
         for (int j = 0; j < MAX_NODES; j++) begin
            if (row_bits[j] && deg_ff[j] != '1) begin
               deg_in[j] = deg_ff[j] + DEG_W'(1);
            end
         end
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (found_ff) begin
            removed_in[pick_ff] = 1'b1;
            step_in = step_ff + CNT_W'(1);
            for (int j = 0; j < MAX_NODES; j++) begin
               if (pick_row[j] && deg_ff[j] != '0) begin
                  deg_in[j] = deg_ff[j] - DEG_W'(1);
               end
            end
         end
         if (run_end) begin
            for (int j = 0; j < MAX_NODES; j++) begin
               deg_in[j] = '0;
            end
            removed_in = '0;
            rows_in    = '0;
            step_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= CNT_W'(NODE_COUNT_RESET);
         removed_ff    <= '0;
         rows_ff       <= '0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int j = 0; j < MAX_NODES; j++) begin
            deg_ff[j] <= '0;
         end
      end else begin
         if (csr_we) begin
            node_count_ff <= csr_wdata;
         end
         removed_ff   <= removed_in;
         rows_ff      <= rows_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         deg_ff       <= deg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load && row_ok) begin
         adj_ff[row_idx] <= row_bits;
      end
      if (cmd.pick) begin
         pick_ff  <= pick_sel;
         found_ff <= |cand;
      end
      if (cmd.emit) begin
         rsp_node_ff <= found_ff ? pick_ff : '0;
         rsp_last_ff <= run_end;
         rsp_cyc_ff  <= !found_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8 - NODE_W){1'b0}}, rsp_node_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_cyc_ff;

endmodule

FILE: sv/kts_checker.sv
// port-level checks of the topological sorter, bound to the top level
// depends on assert_macros.svh and kahn_topological_sort
`include "assert_macros.svh"

module kts_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // stalled result holds
   `KTS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

   // cycle result ends the run and carries node zero
   `KTS_ASSERT(a_cycle_last, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata == 8'd0)

   // no rows taken in the middle of a run
   `KTS_ASSERT(a_no_load_mid_run, clock, reset, rsp_tvalid && !rsp_tlast |-> !req_tready)

   // nothing pending after reset
   `KTS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid)

endmodule

bind kahn_topological_sort kts_checker u_checker (.*);
